>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> rtl/core/rhc_pkg.sv
// package with shared types and constants of the rgb hsv converter
`timescale 1ns / 1ps
`default_nettype none
package rhc_pkg;
  localparam int unsigned HueSector = 256;
  localparam int unsigned HueFull = 1536;
  localparam int unsigned RecipBits = 24;

  typedef enum logic {
    CMD_RGB2HSV = 1'b0,
    CMD_HSV2RGB = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [10:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [10:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic       undef;
  } res_t;
endpackage
`default_nettype wire

>>> rtl/core/rgb_hsv_converter.sv
// rgb hsv converter top level
// pipeline: four register stages
// throughput: one item per cycle, whole pipeline stalls when output is held
// reset: asynchronous active low, clears the stage valid bits only
`timescale 1ns / 1ps
`default_nettype none
module rgb_hsv_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // in_red, in_green, in_blue, in_hue, in_saturation,
                                          // in_value
  input  wire logic        s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [55:0] m_axis_tdata,  // out_red, out_green, out_blue, out_hue, out_saturation,
                                          // out_value
  output logic             m_axis_tuser   // hue_undefined
);
  localparam int Stages = 4;
  logic [Stages-1:0] vld_q;
  logic en;
  rhc_pkg::item_t it, i1_q, i2_q, i3_q;
  logic cmd4_q;
  assign en = !vld_q[Stages-1] || m_axis_tready;
  assign s_axis_tready = en;

  assign it.cmd = s_axis_tuser;
  assign it.r = s_axis_tdata[7:0];
  assign it.g = s_axis_tdata[15:8];
  assign it.b = s_axis_tdata[23:16];
  assign it.h = s_axis_tdata[34:24];
  assign it.s = s_axis_tdata[42:35];
  assign it.v = s_axis_tdata[50:43];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], s_axis_tvalid};
    end
  end

  // stage 1: max, min, sector operands
  logic [7:0] mx, mn, pos, neg, df;
  logic [10:0] base;
  logic sgn;
  logic [7:0] mx_q, rg_q, df_q;
  logic [10:0] base_q;
  logic sgn_q;
  always_comb begin
    mx = it.r; mn = it.r;
    if (it.g > mx) mx = it.g;
    if (it.b > mx) mx = it.b;
    if (it.g < mn) mn = it.g;
    if (it.b < mn) mn = it.b;
    if (mx == it.r) begin
      base = 11'd0; pos = it.g; neg = it.b;
    end else if (mx == it.g) begin
      base = 11'd512; pos = it.b; neg = it.r;
    end else begin
      base = 11'd1024; pos = it.r; neg = it.g;
    end
    sgn = pos < neg;
    df = sgn ? neg - pos : pos - neg;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      i1_q <= it; mx_q <= mx; rg_q <= mx - mn; df_q <= df;
      base_q <= base; sgn_q <= sgn;
    end
  end

  // stages 2 and 3: dividers
  logic [9:0] satq, magq;
  rhc_div u_sat (.clk_i, .en_i(en),
    .num_i(18'({2'd0, rg_q, 8'd0} - {10'd0, rg_q}) * 18'd2 + {10'd0, mx_q}),
    .den_i(mx_q), .quo_o(satq));
  rhc_div u_hue (.clk_i, .en_i(en),
    .num_i({1'b0, df_q, 9'd0} + {10'd0, rg_q}),
    .den_i(rg_q), .quo_o(magq));
  logic [7:0] mx2_q, rg2_q, mx3_q, rg3_q;
  logic [10:0] base2_q, base3_q;
  logic sgn2_q, sgn3_q;
  logic [9:0] satq_q, magq_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      i2_q <= i1_q; mx2_q <= mx_q; rg2_q <= rg_q; base2_q <= base_q; sgn2_q <= sgn_q;
      i3_q <= i2_q; mx3_q <= mx2_q; rg3_q <= rg2_q; base3_q <= base2_q; sgn3_q <= sgn2_q;
      satq_q <= satq; magq_q <= magq;
      cmd4_q <= i3_q.cmd;
    end
  end

  logic [7:0] hr, hg, hb;
  rhc_h2r u_h2r (.clk_i, .en_i(en), .h_i(i1_q.h), .s_i(i1_q.s), .v_i(i1_q.v),
    .r_o(hr), .g_o(hg), .b_o(hb));

  // stage 4: assemble
  logic [11:0] hsum;
  rhc_pkg::res_t res_d, res_q;
  always_comb begin
    hsum = sgn3_q ? {1'b0, base3_q} + 12'd1536 - {2'd0, magq_q}
                  : {1'b0, base3_q} + {2'd0, magq_q};
    if (hsum >= 12'd1536) hsum = hsum - 12'd1536;
    res_d = '{r: i3_q.r, g: i3_q.g, b: i3_q.b, h: i3_q.h, s: i3_q.s, v: i3_q.v,
              undef: 1'b0};
    if (i3_q.cmd == rhc_pkg::CMD_RGB2HSV) begin
      res_d.v = mx3_q;
      res_d.s = (mx3_q == 8'd0) ? 8'd0 : satq_q[7:0];
      res_d.h = (rg3_q == 8'd0) ? 11'd0 : hsum[10:0];
      res_d.undef = mx3_q == 8'd0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  logic [7:0] or_, og, ob;
  assign or_ = (cmd4_q == rhc_pkg::CMD_HSV2RGB) ? hr : res_q.r;
  assign og = (cmd4_q == rhc_pkg::CMD_HSV2RGB) ? hg : res_q.g;
  assign ob = (cmd4_q == rhc_pkg::CMD_HSV2RGB) ? hb : res_q.b;

  assign m_axis_tvalid = vld_q[Stages-1];
  assign m_axis_tdata = {5'd0, res_q.v, res_q.s, res_q.h, ob, og, or_};
  assign m_axis_tuser = res_q.undef;
endmodule
`default_nettype wire

>>> rtl/core/rhc_div.sv
// quotient of a numerator below 2^18 by twice an eight bit divisor, by reciprocal and correction
`timescale 1ns / 1ps
`default_nettype none
module rhc_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [17:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic      [9:0]  quo_o
);
  logic [23:0] rec;
  logic [41:0] prod_d;
  logic [17:0] num_q;
  logic [8:0]  den2_q;
  logic [41:0] prod_q;
  logic [9:0]  est;
  logic [18:0] back;
  logic [23:0] rec_tab [256];

  // reciprocal table: ceil(2^24 / (2*d)) for d in 1..255
  assign rec_tab[0] = '0;
  for (genvar k = 1; k < 256; k++) begin : g_rec
    localparam int unsigned Rec =
      ((32'd1 << rhc_pkg::RecipBits) + 32'(2 * k) - 32'd1) / 32'(2 * k);
    assign rec_tab[k] = 24'(Rec);
  end

  always_comb begin
    rec = rec_tab[den_i];
    prod_d = {24'd0, num_i} * {18'd0, rec};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      num_q  <= num_i;
      den2_q <= {den_i, 1'b0};
    end
  end

  always_comb begin
    est  = prod_q[33:24];
    back = 19'({9'd0, est} * {10'd0, den2_q});
    if (back > {1'b0, num_q}) begin
      quo_o = est - 10'd1;
    end else if ({1'b0, num_q} - back >= {10'd0, den2_q}) begin
      quo_o = est + 10'd1;
    end else begin
      quo_o = est;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rhc_h2r.sv
// hsv to rgb channel math, registered
`timescale 1ns / 1ps
`default_nettype none
module rhc_h2r (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [10:0] h_i,
  input  wire logic [7:0]  s_i,
  input  wire logic [7:0]  v_i,
  output logic      [7:0]  r_o,
  output logic      [7:0]  g_o,
  output logic      [7:0]  b_o
);
  logic [10:0] hp;
  logic [2:0]  sec_d, sec_q, sec2_q;
  logic [8:0]  fw;
  logic [15:0] vs_d, vs_q;
  logic [8:0]  fw_q;
  logic [7:0]  v_q;
  logic [24:0] c_q, x_q, m_q;
  logic [24:0] rr, gg, bb;
  logic [7:0]  r_q, g_q, b_q;

  always_comb begin
    hp = (h_i >= 11'(rhc_pkg::HueFull)) ? h_i - 11'(rhc_pkg::HueFull) : h_i;
    sec_d = hp[10:8];
    fw = sec_d[0] ? 9'(rhc_pkg::HueSector) - {1'b0, hp[7:0]} : {1'b0, hp[7:0]};
    vs_d = {8'd0, v_i} * {8'd0, s_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vs_q <= vs_d;
      fw_q <= fw;
      sec_q <= sec_d;
      v_q <= v_i;
      c_q <= {1'b0, vs_q, 8'd0};
      x_q <= {9'd0, vs_q} * {16'd0, fw_q};
      m_q <= ({9'd0, v_q, 8'd0} * 25'd255) - {1'b0, vs_q, 8'd0};
      sec2_q <= sec_q;
    end
  end

  // (a + 32640) / 65280 as (t >> 8) / 255, done by u * 257 >> 16 with u = (t >> 8) + 1
  function automatic logic [7:0] rnd(input logic [24:0] a);
    logic [24:0] t;
    logic [16:0] u;
    logic [25:0] p;
    t = a + 25'd32640;
    u = t[24:8] + 17'd1;
    p = {9'd0, u} * 26'd257;
    rnd = p[23:16];
  endfunction

  always_comb begin
    case (sec2_q)
      3'd0: begin rr = c_q; gg = x_q; bb = '0; end
      3'd1: begin rr = x_q; gg = c_q; bb = '0; end
      3'd2: begin rr = '0; gg = c_q; bb = x_q; end
      3'd3: begin rr = '0; gg = x_q; bb = c_q; end
      3'd4: begin rr = x_q; gg = '0; bb = c_q; end
      default: begin rr = c_q; gg = '0; bb = x_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= rnd(rr + m_q);
      g_q <= rnd(gg + m_q);
      b_q <= rnd(bb + m_q);
    end
  end

  assign r_o = r_q;
  assign g_o = g_q;
  assign b_o = b_q;
endmodule
`default_nettype wire

>>> rtl/core/rhc_checker.sv
// port level checker of the rgb hsv converter and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rhc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `ASSERT_NEXT(a_vld, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPLIES(a_rdy, clk_i, rst_ni, m_axis_tready, s_axis_tready)
  `ASSERT_IMPLIES(a_hue, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[50:24] == 27'd0)
endmodule
bind rgb_hsv_converter rhc_checker u_rhc_checker (.*);
`default_nettype wire
